// ===== rtl/core/gpm_pkg.sv =====
// ----------------------------------------------------------------------------
// gpm_pkg: shared types and constants for the gyro pointer motion block
// Holds the item structs, the register indexes, the controller-datapath
// command and status structs, and the fixed sizes of the arithmetic.
// ----------------------------------------------------------------------------
package gpm_pkg;

  // Number of samples averaged per axis to find the resting offset.
  localparam int unsigned CAL_SAMPLES = 500;
  localparam int unsigned CAL_CNT_W   = $clog2(CAL_SAMPLES + 1);

  localparam int unsigned RATE_W   = 16;
  localparam int unsigned MOVE_W   = 8;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned SUM_W    = 25;
  // The divider only ever takes a 16-bit corrected rate magnitude.
  localparam int unsigned DIV_W    = RATE_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W + 1);

  // Offset division by CAL_SAMPLES as a multiply by a rounded-up reciprocal.
  // With the shift set to the sum width plus the divisor's bit length, the
  // product's upper bits equal the truncated quotient for every sum magnitude.
  localparam int unsigned RECIP_SHIFT = SUM_W + $clog2(CAL_SAMPLES);
  localparam int unsigned RECIP_W     = SUM_W + 1;
  localparam int unsigned PROD_W      = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_MUL =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));

  localparam logic [CFG_W-1:0] SENS_RESET = 16'd600;
  localparam logic [CFG_W-1:0] DZ_RESET   = 16'd10;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_SENSITIVITY = 1'b0,
    CFG_DEADZONE    = 1'b1
  } cfg_idx_e;

  // Target of a division: one of the two motion steps.
  typedef enum logic [0:0] {
    SEL_MOVE_H = 1'b0,
    SEL_MOVE_V = 1'b1
  } div_sel_e;

  typedef struct packed {
    logic signed [RATE_W-1:0] rate_x;
    logic signed [RATE_W-1:0] rate_z;
  } in_item_t;

  typedef struct packed {
    logic signed [MOVE_W-1:0] move_horizontal;
    logic signed [MOVE_W-1:0] move_vertical;
  } out_item_t;

  typedef struct packed {
    logic     capture;
    logic     accum;
    logic     bias_store;
    logic     div_start;
    div_sel_e div_sel;
    logic     div_store;
    logic     load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic calibrating;
    logic cal_last;
    logic div_done;
    logic motion_nz;
    logic out_free;
  } ctrl_stat_t;

endpackage

// ===== rtl/core/gyro_pointer_motion.sv =====
// ----------------------------------------------------------------------------
// gyro_pointer_motion: gyro rate samples to pointer steps
// Calibration items go through the accumulate state, the last also through the
// offset state as it sets both offsets. A motion item offers a nonzero result
// after two 16-step runs of the shared bit-serial divider; one item is in
// flight at a time, so none is taken before the last is done. Reset clears
// calibration, offsets and output valid, loads sensitivity 600 and deadzone 10.
// ----------------------------------------------------------------------------
module gyro_pointer_motion (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  gpm_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output gpm_pkg::out_item_t out_data_o,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [15:0]        cfg_data_i
);
  import gpm_pkg::*;

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  gpm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  gpm_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

endmodule

// ===== rtl/core/gpm_divider.sv =====
// ----------------------------------------------------------------------------
// gpm_divider: iterative unsigned restoring divider
// Produces one quotient bit per cycle, so a 16-bit dividend takes 16 steps.
// ----------------------------------------------------------------------------
module gpm_divider (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [gpm_pkg::DIV_W-1:0] dividend_i,
  input  logic [15:0]               divisor_i,
  output logic                      done_o,
  output logic [gpm_pkg::DIV_W-1:0] quotient_o
);
  import gpm_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [15:0]          rem_q, rem_d;
  logic [DIV_W-1:0]     quo_q, quo_d;
  logic [15:0]          dsr_q, dsr_d;
  logic [16:0]          shifted;
  logic                 fits;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  assign shifted = {rem_q, quo_q[DIV_W-1]};
  assign fits    = shifted >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      rem_d  = '0;
      dsr_d  = divisor_i;
      quo_d  = dividend_i;
      cnt_d  = DIV_CNT_W'(DIV_W);
    end else if (busy_q) begin
      rem_d = fits ? 16'(shifted - {1'b0, dsr_q}) : shifted[15:0];
      quo_d = {quo_q[DIV_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== rtl/core/gpm_datapath.sv =====
// ----------------------------------------------------------------------------
// gpm_datapath: calibration sums, offsets, correction and motion steps
// Holds the configuration registers, the captured sample, the output
// register, and drives the shared divider under controller commands.
// ----------------------------------------------------------------------------
module gpm_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  gpm_pkg::ctrl_cmd_t    cmd_i,
  output gpm_pkg::ctrl_stat_t   stat_o,
  input  gpm_pkg::in_item_t     in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output gpm_pkg::out_item_t    out_data_o,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [15:0]           cfg_data_i
);
  import gpm_pkg::*;

  logic [CFG_W-1:0]          sens_q, dz_q;
  logic [CAL_CNT_W-1:0]      cnt_q;
  logic signed [SUM_W-1:0]   sum_x_q, sum_z_q;
  logic signed [RATE_W-1:0]  bias_x_q, bias_z_q;
  logic signed [RATE_W-1:0]  raw_x_q, raw_z_q;
  logic signed [MOVE_W-1:0]  mh_q, mv_q;
  logic                      out_valid_q;
  out_item_t                 out_q;

  logic signed [RATE_W:0]    corr_x, corr_z;
  logic [RATE_W-1:0]         mag_x, mag_z;
  logic [SUM_W-1:0]          smag_x, smag_z;
  logic [PROD_W-1:0]         prod_x, prod_z;
  logic [RATE_W-1:0]         bias_x_d, bias_z_d;
  logic [15:0]               sens_div;
  logic [DIV_W-1:0]          dividend;
  logic                      neg;
  logic                      in_dz;
  logic                      div_done;
  logic [DIV_W-1:0]          quotient;
  logic [MOVE_W-1:0]         move_val;

  // Clamp a quotient magnitude with its sign into a signed byte.
  function automatic logic [MOVE_W-1:0] saturate(input logic n, input logic [15:0] q);
    logic [MOVE_W-1:0] r;
    if (n) begin
      r = (q > 16'd128) ? 8'h80 : 8'(~q[MOVE_W-1:0] + 1'b1);
    end else begin
      r = (q > 16'd127) ? 8'h7f : q[MOVE_W-1:0];
    end
    return r;
  endfunction

  // Corrected rates and their magnitudes.
  assign corr_x = 17'(raw_x_q) - 17'(bias_x_q);
  assign corr_z = 17'(raw_z_q) - 17'(bias_z_q);
  assign mag_x  = corr_x[RATE_W] ? 16'(-corr_x) : corr_x[RATE_W-1:0];
  assign mag_z  = corr_z[RATE_W] ? 16'(-corr_z) : corr_z[RATE_W-1:0];
  assign smag_x = sum_x_q[SUM_W-1] ? SUM_W'(-sum_x_q) : SUM_W'(sum_x_q);
  assign smag_z = sum_z_q[SUM_W-1] ? SUM_W'(-sum_z_q) : SUM_W'(sum_z_q);

  // Offsets: sum magnitude times the reciprocal, truncated toward zero, signed back.
  assign prod_x   = PROD_W'(smag_x) * PROD_W'(RECIP_MUL);
  assign prod_z   = PROD_W'(smag_z) * PROD_W'(RECIP_MUL);
  assign bias_x_d = sum_x_q[SUM_W-1] ? RATE_W'(-prod_x[RECIP_SHIFT +: RATE_W])
                                     : prod_x[RECIP_SHIFT +: RATE_W];
  assign bias_z_d = sum_z_q[SUM_W-1] ? RATE_W'(-prod_z[RECIP_SHIFT +: RATE_W])
                                     : prod_z[RECIP_SHIFT +: RATE_W];

  // A zero sensitivity divides by one.
  assign sens_div = (sens_q == '0) ? 16'd1 : sens_q;

  // Operand selection for the shared divider.
  always_comb begin
    case (cmd_i.div_sel)
      SEL_MOVE_H: begin
        dividend = mag_z;
        neg      = corr_z[RATE_W];
        in_dz    = mag_z <= dz_q;
      end
      default: begin
        dividend = mag_x;
        neg      = corr_x[RATE_W];
        in_dz    = mag_x <= dz_q;
      end
    endcase
  end

  gpm_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (sens_div),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Signed motion step from the quotient magnitude.
  assign move_val = in_dz ? '0 : saturate(neg, quotient);

  // Configuration, calibration and offset state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sens_q   <= SENS_RESET;
      dz_q     <= DZ_RESET;
      cnt_q    <= '0;
      sum_x_q  <= '0;
      sum_z_q  <= '0;
      bias_x_q <= '0;
      bias_z_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_SENSITIVITY: sens_q <= cfg_data_i;
          CFG_DEADZONE:    dz_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.accum) begin
        sum_x_q <= sum_x_q + SUM_W'(raw_x_q);
        sum_z_q <= sum_z_q + SUM_W'(raw_z_q);
        cnt_q   <= cnt_q + 1'b1;
      end
      if (cmd_i.bias_store) begin
        bias_x_q <= bias_x_d;
        bias_z_q <= bias_z_d;
      end
    end
  end

  // Captured sample and motion steps.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      raw_x_q <= in_data_i.rate_x;
      raw_z_q <= in_data_i.rate_z;
    end
    if (cmd_i.div_store && cmd_i.div_sel == SEL_MOVE_H) begin
      mh_q <= move_val;
    end
    if (cmd_i.div_store && cmd_i.div_sel == SEL_MOVE_V) begin
      mv_q <= move_val;
    end
    if (cmd_i.load_out) begin
      out_q.move_horizontal <= mh_q;
      out_q.move_vertical   <= mv_q;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign stat_o.calibrating = cnt_q != CAL_CNT_W'(CAL_SAMPLES);
  assign stat_o.cal_last    = cnt_q == CAL_CNT_W'(CAL_SAMPLES - 1);
  assign stat_o.div_done    = div_done;
  assign stat_o.motion_nz   = (mh_q != '0) || (mv_q != '0);
  assign stat_o.out_free    = !out_valid_q || out_ready_i;

endmodule

// ===== rtl/core/gpm_ctrl.sv =====
// ----------------------------------------------------------------------------
// gpm_ctrl: sequencing state machine
// Accepts an item, steps calibration or the two axis divisions, and
// hands a nonzero result to the output register.
// ----------------------------------------------------------------------------
module gpm_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  gpm_pkg::ctrl_stat_t stat_i,
  output gpm_pkg::ctrl_cmd_t  cmd_o
);
  import gpm_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_ACCUM   = 8'b0000_0010,
    S_BIAS    = 8'b0000_0100,
    S_MH_GO   = 8'b0000_1000,
    S_MH_WAIT = 8'b0001_0000,
    S_MV_GO   = 8'b0010_0000,
    S_MV_WAIT = 8'b0100_0000,
    S_EMIT    = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = state_q == S_IDLE;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = stat_i.calibrating ? S_ACCUM : S_MH_GO;
        end
      end
      S_ACCUM: begin
        cmd_o.accum = 1'b1;
        state_d = stat_i.cal_last ? S_BIAS : S_IDLE;
      end
      S_BIAS: begin
        // Both offsets come from the final sums in one step.
        cmd_o.bias_store = 1'b1;
        state_d = S_IDLE;
      end
      S_MH_GO: begin
        cmd_o.div_sel   = SEL_MOVE_H;
        cmd_o.div_start = 1'b1;
        state_d = S_MH_WAIT;
      end
      S_MH_WAIT: begin
        cmd_o.div_sel   = SEL_MOVE_H;
        cmd_o.div_store = stat_i.div_done;
        if (stat_i.div_done) state_d = S_MV_GO;
      end
      S_MV_GO: begin
        cmd_o.div_sel   = SEL_MOVE_V;
        cmd_o.div_start = 1'b1;
        state_d = S_MV_WAIT;
      end
      S_MV_WAIT: begin
        cmd_o.div_sel   = SEL_MOVE_V;
        cmd_o.div_store = stat_i.div_done;
        if (stat_i.div_done) state_d = S_EMIT;
      end
      S_EMIT: begin
        // A result with no motion on either axis is dropped.
        if (!stat_i.motion_nz) begin
          state_d = S_IDLE;
        end else if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== verif/gyro_pointer_motion_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gyro_pointer_motion_test: self-checking bench for the gyro pointer block
// Runs the calibration pass, a table of directed samples over several
// register settings, then random phases with fresh settings. Every accepted
// sample goes through a local predictor, and each result is checked against
// the oldest predicted step. Both handshakes stall at random.
// ----------------------------------------------------------------------------
module gyro_pointer_motion_test;
  import gpm_pkg::*;

  // How a directed row is checked.
  typedef enum logic [1:0] {
    CHK_MODEL = 2'd0,
    CHK_NONE  = 2'd1,
    CHK_STEP  = 2'd2
  } row_chk_e;

  // One directed sample. With rel set, the rates are offsets from the learned bias.
  typedef struct packed {
    logic [15:0]        sens;
    logic [15:0]        dz;
    logic               rel;
    logic signed [15:0] x;
    logic signed [15:0] z;
    row_chk_e           chk;
    logic signed [7:0]  h;
    logic signed [7:0]  v;
  } dir_row_t;

  localparam int SETTLE_CYCLES = 80;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_ITEMS  = 380;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready_o;
  in_item_t    in_data = '0;
  logic        out_valid_o;
  logic        out_ready = 1'b0;
  out_item_t   out_data_o;
  logic        cfg_we = 1'b0;
  logic        cfg_idx = 1'b0;
  logic [15:0] cfg_data = '0;

  // Predictor state and the register copies it uses.
  int                 cal_taken = 0;
  longint             cal_sum_x = 0;
  longint             cal_sum_z = 0;
  logic signed [15:0] ofs_x = '0;
  logic signed [15:0] ofs_z = '0;
  logic [15:0]        cur_sens = SENS_RESET;
  logic [15:0]        cur_dz = DZ_RESET;

  out_item_t pending_steps [$];
  int        fail_cnt = 0;

  // Stall control shared between the stimulus and the receiver.
  logic calm = 1'b0;
  logic hold_go = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;

  dir_row_t dir_rows [0:22] = '{
    '{16'd600, 16'd10, 1'b1, 16'sd0, 16'sd0, CHK_NONE, 8'sd0, 8'sd0},
    '{16'd600, 16'd10, 1'b1, 16'sd3000, -16'sd3000, CHK_STEP, -8'sd5, 8'sd5},
    '{16'd600, 16'd10, 1'b1, 16'sd599, -16'sd599, CHK_NONE, 8'sd0, 8'sd0},
    '{16'd600, 16'd10, 1'b1, 16'sd10, -16'sd11, CHK_MODEL, 8'sd0, 8'sd0},
    '{16'd600, 16'd10, 1'b1, -16'sd1300, 16'sd1799, CHK_MODEL, 8'sd0, 8'sd0},
    '{16'd1, 16'd10, 1'b1, 16'sd10, 16'sd11, CHK_STEP, 8'sd11, 8'sd0},
    '{16'd1, 16'd10, 1'b1, -16'sd11, -16'sd10, CHK_STEP, 8'sd0, -8'sd11},
    '{16'd1, 16'd0, 1'b0, 16'sh7FFF, 16'sh8000, CHK_STEP, 8'sh80, 8'sh7F},
    '{16'd1, 16'd0, 1'b1, 16'sd127, 16'sd128, CHK_STEP, 8'sh7F, 8'sh7F},
    '{16'd1, 16'd0, 1'b1, -16'sd128, -16'sd129, CHK_STEP, 8'sh80, 8'sh80},
    '{16'd1, 16'd0, 1'b1, 16'sd1, -16'sd1, CHK_STEP, -8'sd1, 8'sd1},
    '{16'd1, 16'd0, 1'b1, 16'sd0, 16'sd0, CHK_NONE, 8'sd0, 8'sd0},
    '{16'd0, 16'd0, 1'b0, 16'sh8000, 16'sh7FFF, CHK_STEP, 8'sh7F, 8'sh80},
    '{16'd0, 16'd0, 1'b1, -16'sd5, 16'sd100, CHK_STEP, 8'sd100, -8'sd5},
    '{16'd7, 16'd0, 1'b1, -16'sd20, 16'sd20, CHK_STEP, 8'sd2, -8'sd2},
    '{16'd7, 16'd0, 1'b1, 16'sd6, -16'sd6, CHK_NONE, 8'sd0, 8'sd0},
    '{16'd7, 16'd0, 1'b0, 16'sh5555, 16'shAAAA, CHK_MODEL, 8'sd0, 8'sd0},
    '{16'd65535, 16'd0, 1'b0, 16'sh7FFF, 16'sh7FFF, CHK_NONE, 8'sd0, 8'sd0},
    '{16'd65535, 16'd0, 1'b0, 16'sh8000, 16'sh8000, CHK_NONE, 8'sd0, 8'sd0},
    '{16'd1, 16'd65535, 1'b0, 16'sh7FFF, 16'sh8000, CHK_NONE, 8'sd0, 8'sd0},
    '{16'd1, 16'd65535, 1'b0, 16'sh8000, 16'sh7FFF, CHK_NONE, 8'sd0, 8'sd0},
    '{16'd3, 16'd5, 1'b1, -16'sd6, 16'sd5, CHK_STEP, 8'sd0, -8'sd2},
    '{16'd3, 16'd5, 1'b0, 16'sh1234, 16'shEDCB, CHK_MODEL, 8'sd0, 8'sd0}
  };

  gyro_pointer_motion dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  // Free-running clock, 12 ns period.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Motion of one axis: bias removal, deadzone, scaling and saturation.
  function automatic logic signed [7:0] axis_step(logic signed [15:0] raw,
                                                  logic signed [15:0] ofs);
    int corr;
    int mag;
    int div;
    int q;
    corr = int'(raw) - int'(ofs);
    mag  = (corr < 0) ? -corr : corr;
    div  = (cur_sens == 16'd0) ? 1 : int'(cur_sens);
    if (mag <= int'(cur_dz)) return 8'sd0;
    q = corr / div;
    if (q > 127) q = 127;
    if (q < -128) q = -128;
    return q[7:0];
  endfunction

  // Advances the calibration state; returns 1 when the sample yields a step.
  function automatic bit predict_step(in_item_t it, output out_item_t step);
    step = '0;
    if (cal_taken < int'(CAL_SAMPLES)) begin
      cal_sum_x += it.rate_x;
      cal_sum_z += it.rate_z;
      cal_taken++;
      if (cal_taken == int'(CAL_SAMPLES)) begin
        ofs_x = 16'(cal_sum_x / longint'(CAL_SAMPLES));
        ofs_z = 16'(cal_sum_z / longint'(CAL_SAMPLES));
      end
      return 1'b0;
    end
    step.move_horizontal = axis_step(it.rate_z, ofs_z);
    step.move_vertical   = axis_step(it.rate_x, ofs_x);
    return (step.move_horizontal != 8'sd0) || (step.move_vertical != 8'sd0);
  endfunction

  function automatic logic signed [15:0] clamp16(int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // A raw rate: full range, or spread around the bias at a scale that moves the pointer.
  function automatic logic signed [15:0] pick_rate(logic signed [15:0] ofs);
    int span;
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: span = 40;
      2: span = (cur_sens == 16'd0) ? 130 : int'(cur_sens) * 130;
      default: span = 4096;
    endcase
    if (span > 65535) span = 65535;
    return clamp16(int'(ofs) + $signed($urandom_range(0, 2 * span)) - span);
  endfunction

  // Offers one sample, records what it should produce, then maybe idles.
  task automatic offer_sample(in_item_t it, row_chk_e chk, out_item_t fixed);
    out_item_t step;
    bit        has_step;
    int        gap;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    has_step = predict_step(it, step);
    case (chk)
      CHK_STEP: pending_steps.push_back(fixed);
      CHK_NONE: ;
      default: if (has_step) pending_steps.push_back(step);
    endcase
    if (!calm && $urandom_range(0, 99) < 8) begin
      gap = $urandom_range(1, 50);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Waits until every step is out and the block has had time to finish.
  task automatic drain_and_rest();
    in_valid <= 1'b0;
    while (pending_steps.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes whichever registers differ from the wanted settings, with the block idle.
  task automatic apply_settings(logic [15:0] sens, logic [15:0] dz);
    if (sens == cur_sens && dz == cur_dz) return;
    drain_and_rest();
    if (sens != cur_sens) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= CFG_SENSITIVITY;
      cfg_data <= sens;
      @(posedge clk_i);
      cur_sens = sens;
    end
    if (dz != cur_dz) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= CFG_DEADZONE;
      cfg_data <= dz;
      @(posedge clk_i);
      cur_dz = dz;
    end
    cfg_we <= 1'b0;
  endtask

  // Receiver: random stalls, a long hold on request, none while calm.
  always @(posedge clk_i) begin
    if (hold_go != hold_seen) begin
      hold_seen <= hold_go;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= 8);
    end
  end

  // Compare each accepted result with the oldest predicted step.
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      if (pending_steps.size() == 0) begin
        if (fail_cnt < 10)
          $display("%0t: unexpected result h=%0d v=%0d", $realtime,
                   out_data_o.move_horizontal, out_data_o.move_vertical);
        fail_cnt++;
      end else begin
        want = pending_steps.pop_front();
        if (out_data_o.move_horizontal !== want.move_horizontal ||
            out_data_o.move_vertical !== want.move_vertical) begin
          if (fail_cnt < 10)
            $display("%0t: step mismatch, want h=%0d v=%0d, got h=%0d v=%0d",
                     $realtime, want.move_horizontal, want.move_vertical,
                     out_data_o.move_horizontal, out_data_o.move_vertical);
          fail_cnt++;
        end
      end
    end
  end

  // Stimulus: calibration, directed table, random phases, then the drain.
  initial begin
    in_item_t    it;
    int          base_x;
    int          base_z;
    int          phase_len;
    int          sent;
    int          guard;
    logic [15:0] sens;
    logic [15:0] dz;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Calibration: a resting offset with noise, every 16th sample full range.
    base_x = $urandom_range(0, 600) - 300;
    base_z = $urandom_range(0, 600) - 300;
    for (int i = 0; i < int'(CAL_SAMPLES); i++) begin
      if (i == 0) begin
        it.rate_x = 16'sh8000;
        it.rate_z = 16'sh7FFF;
      end else if (i == 16) begin
        it.rate_x = 16'sh7FFF;
        it.rate_z = 16'sh8000;
      end else if (i % 16 == 0) begin
        it.rate_x = 16'($urandom);
        it.rate_z = 16'($urandom);
      end else begin
        it.rate_x = clamp16(base_x + $signed($urandom_range(0, 80)) - 40);
        it.rate_z = clamp16(base_z + $signed($urandom_range(0, 80)) - 40);
      end
      offer_sample(it, CHK_MODEL, '0);
    end

    // Directed rows, grouped by register setting.
    foreach (dir_rows[k]) begin
      apply_settings(dir_rows[k].sens, dir_rows[k].dz);
      it.rate_x = dir_rows[k].rel ? ofs_x + dir_rows[k].x : dir_rows[k].x;
      it.rate_z = dir_rows[k].rel ? ofs_z + dir_rows[k].z : dir_rows[k].z;
      offer_sample(it, dir_rows[k].chk, '{dir_rows[k].h, dir_rows[k].v});
    end

    // Random phases, each with its own settings.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: sens = 16'd0;
        1: sens = 16'd1;
        2: sens = 16'd65535;
        3, 4: sens = 16'($urandom_range(1, 16));
        5, 6, 7: sens = 16'($urandom_range(17, 1000));
        default: sens = 16'($urandom_range(1001, 65535));
      endcase
      case ($urandom_range(0, 7))
        0: dz = 16'd0;
        1: dz = 16'd65535;
        6: dz = 16'($urandom_range(65, 2000));
        7: dz = 16'($urandom);
        default: dz = 16'($urandom_range(0, 64));
      endcase
      apply_settings(sens, dz);
      phase_len = $urandom_range(40, 90);
      for (int j = 0; j < phase_len && sent < RANDOM_ITEMS; j++) begin
        // Long output hold while samples keep coming.
        if (sent == 100) hold_go <= ~hold_go;
        // Pause until every step has come out.
        if (sent == 200) drain_and_rest();
        calm <= (sent >= 250 && sent < 330);
        it.rate_x = pick_rate(ofs_x);
        it.rate_z = pick_rate(ofs_z);
        offer_sample(it, CHK_MODEL, '0);
        sent++;
      end
    end

    // Drain, then allow the block's latency for stray results.
    in_valid <= 1'b0;
    calm <= 1'b0;
    guard = 0;
    while (pending_steps.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_steps.size() != 0) begin
      $display("%0d predicted steps never came out", pending_steps.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #40_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/gpm_pkg.sv
rtl/core/gpm_divider.sv
rtl/core/gpm_datapath.sv
rtl/core/gpm_ctrl.sv
rtl/core/gyro_pointer_motion.sv
verif/gyro_pointer_motion_test.sv
